### rtl/lipd_pkg.sv
package lipd_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_AW      = 2;
  localparam int HIST_DEPTH   = 8;
  localparam int HIST_AW      = 3;
  localparam int INDEX_DEPTH  = 64;
  localparam int INDEX_AW     = 6;

  localparam logic [7:0] TAG_FULL_PIXEL = 8'hFF;
  localparam logic [3:0] TAG_DELTA_HI   = 4'hC;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] chan_zero;
    logic [7:0] chan_one;
    logic [7:0] chan_two;
    logic [7:0] chan_three;
    logic       run_final;
    logic       bad_tag;
  } out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_COPY,
    OP_INDEX,
    OP_PIXEL,
    OP_BAD
  } cmd_op_t;

  // arg: copy -> {back[2:0], len_m1[3:0]}, index -> {1'b0, slot[5:0]}
  typedef struct packed {
    cmd_op_t         op;
    logic            clear;
    logic [6:0]      arg;
    logic [3:0][7:0] chan_val;
    logic [3:0]      chan_rel;
  } cmd_t;

  function automatic logic [2:0] eff_channels(input logic [2:0] cnt);
    logic [2:0] n;
    n = cnt;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MAX_CHANNELS)) n = 3'(MAX_CHANNELS);
    return n;
  endfunction

  function automatic logic [31:0] chan_mask(input logic [2:0] n);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // sign-magnitude delta folded into a mod-256 addend
  function automatic logic [7:0] delta_addend(input logic [6:0] mag, input logic plus);
    return plus ? {1'b0, mag} : (8'd0 - {1'b0, mag});
  endfunction

  function automatic logic [5:0] color_hash(input logic [31:0] px);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r = r ^ px[8*i +: 6] ^ {4'b0000, px[8*i+6 +: 2]};
    end
    return r;
  endfunction

endpackage

### rtl/lipd_front.sv
module lipd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  lipd_pkg::in_t   in_data,
  input  logic [2:0]      n_chan,
  output logic            cmd_push,
  output lipd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {PH_RAW, PH_TAG, PH_DELTA} phase_t;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      pos_r, pos_nxt;
  logic [3:0][7:0] val_r, val_nxt;
  logic [3:0]      rel_r, rel_nxt;
  logic [7:0]      b;
  logic            finish;
  logic [1:0]      p0, p1;

  always_comb begin
    b         = in_data.data_byte;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    rel_nxt   = rel_r;
    finish    = 1'b0;
    p0        = pos_r[1:0];
    p1        = pos_r[1:0] + 2'd1;
    cmd       = '0;
    cmd.op    = lipd_pkg::OP_NOP;

    unique case (phase_r)
      PH_RAW: begin
        if (pos_r < n_chan) begin
          val_nxt[p0] = b;
          rel_nxt[p0] = 1'b0;
          pos_nxt     = pos_r + 3'd1;
        end
        if (pos_nxt >= n_chan) finish = 1'b1;
      end
      PH_DELTA: begin
        if ({1'b0, pos_r} + 4'd2 <= {1'b0, n_chan}) begin
          val_nxt[p0] = lipd_pkg::delta_addend({4'b0000, b[2:0]}, b[3]);
          val_nxt[p1] = lipd_pkg::delta_addend({4'b0000, b[6:4]}, b[7]);
          rel_nxt[p0] = 1'b1;
          rel_nxt[p1] = 1'b1;
          pos_nxt     = pos_r + 3'd2;
        end else if (pos_r < n_chan) begin
          val_nxt[p0] = lipd_pkg::delta_addend(b[6:0], b[7]);
          rel_nxt[p0] = 1'b1;
          pos_nxt     = pos_r + 3'd1;
        end
        if (pos_nxt >= n_chan) finish = 1'b1;
      end
      default: begin
        if (!b[7]) begin
          cmd.op  = lipd_pkg::OP_COPY;
          cmd.arg = b[6:0];
        end else if (!b[6]) begin
          cmd.op  = lipd_pkg::OP_INDEX;
          cmd.arg = {1'b0, b[5:0]};
        end else if (b[7:4] == lipd_pkg::TAG_DELTA_HI) begin
          val_nxt    = '0;
          rel_nxt    = 4'b0001;
          val_nxt[0] = lipd_pkg::delta_addend({4'b0000, b[2:0]}, b[3]);
          pos_nxt    = 3'd1;
          if (n_chan <= 3'd1) finish = 1'b1;
          else phase_nxt = PH_DELTA;
        end else if (b == lipd_pkg::TAG_FULL_PIXEL) begin
          phase_nxt = PH_RAW;
          pos_nxt   = '0;
          val_nxt   = '0;
          rel_nxt   = '0;
        end else begin
          cmd.op = lipd_pkg::OP_BAD;
        end
      end
    endcase

    if (finish) begin
      cmd.op       = lipd_pkg::OP_PIXEL;
      cmd.chan_val = val_nxt;
      cmd.chan_rel = rel_nxt;
      phase_nxt    = PH_TAG;
      pos_nxt      = '0;
      val_nxt      = '0;
      rel_nxt      = '0;
    end

    cmd.clear = in_data.end_of_stream;
    if (in_data.end_of_stream) begin
      phase_nxt = PH_RAW;
      pos_nxt   = '0;
      val_nxt   = '0;
      rel_nxt   = '0;
    end

    cmd_push = accept && ((cmd.op != lipd_pkg::OP_NOP) || in_data.end_of_stream);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RAW;
      pos_r   <= '0;
      val_r   <= '0;
      rel_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      val_r   <= val_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

### rtl/lipd_cmd_fifo.sv
module lipd_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lipd_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lipd_pkg::cmd_t  head
);

  lipd_pkg::cmd_t                entry_r [lipd_pkg::CMDQ_DEPTH];
  logic [lipd_pkg::CMDQ_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [lipd_pkg::CMDQ_AW:0]    count_r;
  logic                          do_push, do_pop;

  assign full      = (count_r == (lipd_pkg::CMDQ_AW+1)'(lipd_pkg::CMDQ_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + (lipd_pkg::CMDQ_AW)'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + (lipd_pkg::CMDQ_AW)'(1);
      if (do_push && !do_pop)      count_r <= count_r + (lipd_pkg::CMDQ_AW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (lipd_pkg::CMDQ_AW+1)'(1);
    end
  end

endmodule

### rtl/lipd_back.sv
module lipd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      n_chan,
  input  logic            cmd_valid,
  input  lipd_pkg::cmd_t  head,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lipd_pkg::out_t  out_data
);

  typedef enum logic [1:0] {B_HEAD, B_COPY, B_IDX} bstate_t;

  bstate_t         state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [lipd_pkg::HIST_AW-1:0] back_r, back_nxt;
  logic            clr_pend_r, clr_pend_nxt;
  logic [31:0]     hist_r [lipd_pkg::HIST_DEPTH];
  logic [31:0]     idx_mem [lipd_pkg::INDEX_DEPTH];
  logic [lipd_pkg::INDEX_DEPTH-1:0] idx_vld_r;
  logic [31:0]     idx_q_r;
  logic            idx_hit_r;
  logic            out_valid_r;
  lipd_pkg::out_t  out_data_r;

  logic            slot_free, emit, em_bad, em_final, hist_push, clr;
  logic            mem_we, mem_re;
  logic [31:0]     mask, coded_px, copy_px, idx_px, em_px;
  logic [lipd_pkg::INDEX_AW-1:0] waddr, raddr;

  assign slot_free = !out_valid_r || out_ready;
  assign mask      = lipd_pkg::chan_mask(n_chan);
  assign copy_px   = hist_r[back_r] & mask;
  assign idx_px    = (idx_hit_r ? idx_q_r : 32'd0) & mask;
  assign waddr     = lipd_pkg::color_hash(coded_px);
  assign raddr     = head.arg[lipd_pkg::INDEX_AW-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coded_px[8*i +: 8] = head.chan_rel[i] ? (hist_r[0][8*i +: 8] + head.chan_val[i])
                                            : head.chan_val[i];
    end
    coded_px = coded_px & mask;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    back_nxt     = back_r;
    clr_pend_nxt = clr_pend_r;
    cmd_pop      = 1'b0;
    emit         = 1'b0;
    em_px        = '0;
    em_bad       = 1'b0;
    em_final     = 1'b0;
    hist_push    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    clr          = 1'b0;

    unique case (state_r)
      B_HEAD: begin
        if (cmd_valid) begin
          unique case (head.op)
            lipd_pkg::OP_COPY: begin
              cmd_pop      = 1'b1;
              cnt_nxt      = head.arg[3:0];
              back_nxt     = head.arg[6:4];
              clr_pend_nxt = head.clear;
              state_nxt    = B_COPY;
            end
            lipd_pkg::OP_INDEX: begin
              cmd_pop      = 1'b1;
              mem_re       = 1'b1;
              clr_pend_nxt = head.clear;
              state_nxt    = B_IDX;
            end
            lipd_pkg::OP_PIXEL: begin
              if (slot_free) begin
                cmd_pop   = 1'b1;
                emit      = 1'b1;
                em_px     = coded_px;
                em_final  = 1'b1;
                hist_push = 1'b1;
                mem_we    = 1'b1;
                clr       = head.clear;
              end
            end
            lipd_pkg::OP_BAD: begin
              if (slot_free) begin
                cmd_pop  = 1'b1;
                emit     = 1'b1;
                em_bad   = 1'b1;
                em_final = 1'b1;
                clr      = head.clear;
              end
            end
            default: begin
              cmd_pop = 1'b1;
              clr     = head.clear;
            end
          endcase
        end
      end
      B_COPY: begin
        if (slot_free) begin
          emit      = 1'b1;
          em_px     = copy_px;
          hist_push = 1'b1;
          cnt_nxt   = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            em_final  = 1'b1;
            clr       = clr_pend_r;
            state_nxt = B_HEAD;
          end
        end
      end
      default: begin
        if (slot_free) begin
          emit      = 1'b1;
          em_px     = idx_px;
          hist_push = 1'b1;
          em_final  = 1'b1;
          clr       = clr_pend_r;
          state_nxt = B_HEAD;
        end
      end
    endcase
  end

  // color index storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) idx_mem[waddr] <= coded_px;
    if (mem_re) idx_q_r <= idx_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_HEAD;
      cnt_r       <= '0;
      back_r      <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_vld_r   <= '0;
      idx_hit_r   <= 1'b0;
      for (int i = 0; i < lipd_pkg::HIST_DEPTH; i++) hist_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      back_r     <= back_nxt;
      clr_pend_r <= clr_pend_nxt;
      if (mem_re) idx_hit_r <= idx_vld_r[raddr];
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // end of image wipes history and index after the last result
      if (clr) begin
        idx_vld_r <= '0;
        for (int i = 0; i < lipd_pkg::HIST_DEPTH; i++) hist_r[i] <= '0;
      end else begin
        if (hist_push) begin
          for (int i = lipd_pkg::HIST_DEPTH-1; i > 0; i--) hist_r[i] <= hist_r[i-1];
          hist_r[0] <= em_px;
        end
        if (mem_we) idx_vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.chan_zero  <= em_px[7:0];
      out_data_r.chan_one   <= em_px[15:8];
      out_data_r.chan_two   <= em_px[23:16];
      out_data_r.chan_three <= em_px[31:24];
      out_data_r.run_final  <= em_final;
      out_data_r.bad_tag    <= em_bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/lossless_image_pixel_decoder.sv
// Byte-serial decoder for a QOI-style compressed pixel stream (header parsed
// by software). One compressed byte is taken per transaction on the in_
// channel; each decoded pixel leaves as one transaction on the out_ channel,
// with run_final marking the last pixel caused by a byte and bad_tag marking
// an unsupported tag. A front stage parses tags and gathers raw/delta bytes
// into commands; a 4-entry command queue decouples it from the back stage,
// which owns the 8-pixel history and the 64-entry color index. A byte that
// only extends a token is absorbed by the front stage; a copy token is
// loaded, then read from the history once per produced pixel; an index
// recall waits on the registered read of the index memory. Output is a
// registered stage, so the front keeps parsing while a result waits, until
// the queue fills and in_ready drops. end_of_stream clears history and
// index once the back stage finishes the command its byte carries; the
// index uses per-entry valid bits, so there is no clearing pass after reset
// or end of stream. cfg_wr_data (channel count, reset 4) may only change
// while no transaction is in flight; 0 acts as 1 and values above 4 as 4.
module lossless_image_pixel_decoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lipd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lipd_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [2:0]      cfg_wr_data
);

  logic [2:0]     chan_cnt_r;
  logic [2:0]     n_chan;
  logic           q_full, q_not_empty, q_push, q_pop;
  lipd_pkg::cmd_t q_in, q_head;

  // channel count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 3'(lipd_pkg::MAX_CHANNELS);
    end else if (cfg_wr_en) begin
      chan_cnt_r <= cfg_wr_data;
    end
  end

  assign n_chan   = lipd_pkg::eff_channels(chan_cnt_r);
  // every byte may push one command, so the front only needs a free slot
  assign in_ready = !q_full;

  lipd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_valid && in_ready),
    .in_data  (in_data),
    .n_chan   (n_chan),
    .cmd_push (q_push),
    .cmd      (q_in)
  );

  lipd_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lipd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_chan    (n_chan),
    .cmd_valid (q_not_empty),
    .head      (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/lipd_checker.sv
module lipd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input lipd_pkg::out_t out_data
);

  // error results carry no pixel and always close their byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_tag |->
      out_data.run_final && out_data.chan_zero == 8'd0 && out_data.chan_one == 8'd0 &&
      out_data.chan_two == 8'd0 && out_data.chan_three == 8'd0)
    else $error("bad_tag result with nonzero pixel or without run_final");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("out_valid fell without a transaction");

endmodule

bind lossless_image_pixel_decoder lipd_checker u_lipd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/lipd_pixel_checker.sv
package lipd_tb_codes;

  // tag prefixes not covered by the design package
  localparam logic       TAG_COPY_HI  = 1'b0;
  localparam logic [1:0] TAG_INDEX_HI = 2'b10;
  localparam logic [7:0] TAG_BAD_LO   = 8'hD0;
  localparam logic [7:0] TAG_BAD_HI   = 8'hFE;

endpackage

module lipd_pixel_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  lipd_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  lipd_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [2:0]     cfg_wr_data,
  output int             mismatches,
  output int             in_flight
);

  typedef enum logic [1:0] {GATHER_RAW, AWAIT_TAG, GATHER_DELTA} phase_t;

  phase_t         phase;
  logic [31:0]    partial;
  int unsigned    filled;
  logic [31:0]    color_tab [lipd_pkg::INDEX_DEPTH];
  logic [31:0]    history [lipd_pkg::HIST_DEPTH];
  logic [2:0]     chan_cfg;
  lipd_pkg::out_t due_pixels [$];
  lipd_pkg::out_t batch [$];
  lipd_pkg::out_t want;

  function automatic int unsigned live_chans(logic [2:0] c);
    if (c == 3'd0) return 1;
    if (c > lipd_pkg::MAX_CHANNELS) return lipd_pkg::MAX_CHANNELS;
    return int'(c);
  endfunction

  function automatic logic [31:0] keep_bits(int unsigned n);
    return (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
  endfunction

  function automatic logic [5:0] index_slot(logic [31:0] px, int unsigned n);
    logic [5:0] s;
    logic [7:0] v;
    s = '0;
    for (int i = 0; i < n; i++) begin
      v = px[8*i +: 8];
      s ^= v[5:0] ^ {4'b0000, v[7:6]};
    end
    return s;
  endfunction

  // sign-magnitude step on one channel, wraps mod 256
  function automatic logic [7:0] sm_add(logic [7:0] base, logic [6:0] mag, logic plus);
    return plus ? base + {1'b0, mag} : base - {1'b0, mag};
  endfunction

  function automatic void remember(logic [31:0] px);
    for (int i = lipd_pkg::HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = px;
  endfunction

  function automatic void record(logic [31:0] px, logic bad);
    lipd_pkg::out_t r;
    r.chan_zero  = px[7:0];
    r.chan_one   = px[15:8];
    r.chan_two   = px[23:16];
    r.chan_three = px[31:24];
    r.run_final  = 1'b0;
    r.bad_tag    = bad;
    batch = {batch, r};
  endfunction

  function automatic void close_pixel(int unsigned n);
    logic [31:0] px;
    px = partial & keep_bits(n);
    color_tab[index_slot(px, n)] = px;
    remember(px);
    record(px, 1'b0);
    phase   = AWAIT_TAG;
    filled  = 0;
    partial = '0;
  endfunction

  function automatic void clear_image();
    phase   = GATHER_RAW;
    partial = '0;
    filled  = 0;
    foreach (color_tab[i]) color_tab[i] = '0;
    foreach (history[i]) history[i] = '0;
  endfunction

  // one stream byte in, the pixels it releases appended to due_pixels
  function automatic void decode_byte(logic [7:0] b, logic eos);
    int unsigned    n;
    int unsigned    run_len;
    logic [31:0]    keep;
    logic [31:0]    base;
    logic [31:0]    px;
    lipd_pkg::out_t r;
    n    = live_chans(chan_cfg);
    keep = keep_bits(n);
    base = history[0];
    batch.delete();
    case (phase)
      GATHER_RAW: begin
        if (filled < n) begin
          partial[8*filled +: 8] = b;
          filled++;
        end
        if (filled >= n) close_pixel(n);
      end
      GATHER_DELTA: begin
        if (filled + 2 <= n) begin
          partial[8*filled +: 8]     = sm_add(base[8*filled +: 8], {4'b0, b[2:0]}, b[3]);
          partial[8*filled + 8 +: 8] = sm_add(base[8*filled + 8 +: 8], {4'b0, b[6:4]}, b[7]);
          filled += 2;
        end else if (filled < n) begin
          // odd last channel gets the wide 7-bit magnitude
          partial[8*filled +: 8] = sm_add(base[8*filled +: 8], b[6:0], b[7]);
          filled++;
        end
        if (filled >= n) close_pixel(n);
      end
      default: begin
        if (b[7] == lipd_tb_codes::TAG_COPY_HI) begin
          run_len = int'(b[3:0]) + 1;
          for (int k = 0; k < run_len; k++) begin
            px = history[b[6:4]] & keep;
            remember(px);
            record(px, 1'b0);
          end
        end else if (b[7:6] == lipd_tb_codes::TAG_INDEX_HI) begin
          px = color_tab[b[5:0]] & keep;
          remember(px);
          record(px, 1'b0);
        end else if (b[7:4] == lipd_pkg::TAG_DELTA_HI) begin
          partial      = '0;
          partial[7:0] = sm_add(base[7:0], {4'b0, b[2:0]}, b[3]);
          filled       = 1;
          if (filled >= n) close_pixel(n);
          else phase = GATHER_DELTA;
        end else if (b == lipd_pkg::TAG_FULL_PIXEL) begin
          phase   = GATHER_RAW;
          filled  = 0;
          partial = '0;
        end else begin
          record('0, 1'b1);
        end
      end
    endcase
    foreach (batch[i]) begin
      r = batch[i];
      r.run_final = (i == batch.size() - 1);
      due_pixels = {due_pixels, r};
    end
    if (eos) clear_image();
  endfunction

  function automatic void note_miss(string what, logic [7:0] exp_v, logic [7:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg   = 3'd4;
      mismatches = 0;
      clear_image();
      due_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none, actual %p", $time, out_data);
        end else begin
          want = due_pixels.pop_front();
          if (out_data.chan_zero != want.chan_zero)
            note_miss("chan_zero", want.chan_zero, out_data.chan_zero);
          if (out_data.chan_one != want.chan_one)
            note_miss("chan_one", want.chan_one, out_data.chan_one);
          if (out_data.chan_two != want.chan_two)
            note_miss("chan_two", want.chan_two, out_data.chan_two);
          if (out_data.chan_three != want.chan_three)
            note_miss("chan_three", want.chan_three, out_data.chan_three);
          if (out_data.run_final != want.run_final)
            note_miss("run_final", {7'b0, want.run_final}, {7'b0, out_data.run_final});
          if (out_data.bad_tag != want.bad_tag)
            note_miss("bad_tag", {7'b0, want.bad_tag}, {7'b0, out_data.bad_tag});
        end
      end
      if (in_valid && in_ready) decode_byte(in_data.data_byte, in_data.end_of_stream);
      if (cfg_wr_en) chan_cfg = cfg_wr_data;
    end
    in_flight <= due_pixels.size();
  end

endmodule

### sim/lossless_image_pixel_decoder_tb.sv
// Stimulus and verdict for the pixel decoder. The checker instance beside the
// block does all prediction and comparison; this module only feeds bytes and
// channel-count writes, throttles the result side and reports the outcome.
module lossless_image_pixel_decoder_tb;

  // result-side throttle patterns, each held for a random stretch of cycles
  typedef enum logic [2:0] {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_COMB, SINK_SLOW} sink_mode_t;

  localparam int unsigned PHASE_BYTES = 14;  // minimum bytes sent per channel-count setting
  localparam int unsigned QUIET_CYC   = 40;  // lets commands that make no pixel leave the queue

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  lipd_pkg::in_t  in_data     = '0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  lipd_pkg::out_t out_data;
  logic           cfg_wr_en   = 1'b0;
  logic [2:0]     cfg_wr_data = 3'd4;
  int             fail_count;
  int             pixels_due;

  int unsigned burst_left = 0;
  int unsigned sent_bytes = 0;
  int unsigned chans      = 4;  // effective channel count, used to shape tokens
  sink_mode_t  sink_mode  = SINK_OPEN;
  int unsigned sink_left  = 0;
  int unsigned sink_tick  = 0;
  logic [7:0]  image_bytes [$];
  logic [5:0]  hot_slots [$];   // index slots known to hold a pixel
  logic [2:0]  cfg_plan [7] = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd4, 3'd6};

  lossless_image_pixel_decoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lipd_pixel_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (fail_count),
    .in_flight   (pixels_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: picks a throttle pattern, holds it a while, then picks again.
  // SINK_OPEN gives long stretches of back-to-back transactions.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 4));
      sink_left <= $urandom_range(16, 80);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_tick <= sink_tick + 1;
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
      SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      SINK_COMB:   out_ready <= ((sink_tick % 7) < 4);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Sender: bytes go out in bursts of random length; between bursts valid
  // drops for a random gap (sometimes none). Returns on the edge that
  // completes the transaction.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  // Idle the sender until every predicted pixel is out, then a quiet period
  // so bytes that make no pixel have also cleared the block.
  task automatic drain(input int unsigned quiet);
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic set_channels(input logic [2:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    chans = (v == 3'd0) ? 1
          : ((v > lipd_pkg::MAX_CHANNELS) ? lipd_pkg::MAX_CHANNELS : int'(v));
  endtask

  // index slot a raw pixel lands in; lets recall tags hit live entries
  function automatic logic [5:0] slot_of(logic [31:0] px);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) s ^= px[8*i +: 6] ^ {4'b0000, px[8*i + 6 +: 2]};
    return s;
  endfunction

  // append one raw pixel (chans bytes) and note its index slot
  task automatic add_raw_pixel();
    logic [31:0] px;
    px = $urandom();
    for (int i = chans; i < 4; i++) px[8*i +: 8] = 8'h00;
    for (int i = 0; i < chans; i++) image_bytes = {image_bytes, px[8*i +: 8]};
    hot_slots = {hot_slots, slot_of(px)};
  endtask

  // One image: raw first pixel, a mix of well-formed tokens with some bad
  // tags and stray bytes, end_of_stream on the final byte.
  task automatic send_image(input int unsigned n_tokens);
    int unsigned pick;
    logic [3:0]  len_m1;
    image_bytes.delete();
    hot_slots.delete();
    add_raw_pixel();
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        // copy runs: mostly short, now and then up to 16 pixels
        len_m1 = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 3));
        image_bytes = {image_bytes,
                       {lipd_tb_codes::TAG_COPY_HI, 3'($urandom_range(0, 7)), len_m1}};
      end else if (pick < 46) begin
        if (hot_slots.size() != 0 && $urandom_range(0, 2) != 0)
          image_bytes = {image_bytes,
                         {lipd_tb_codes::TAG_INDEX_HI,
                          hot_slots[$urandom_range(0, hot_slots.size() - 1)]}};
        else
          image_bytes = {image_bytes,
                         {lipd_tb_codes::TAG_INDEX_HI, 6'($urandom_range(0, 63))}};
      end else if (pick < 72) begin
        image_bytes = {image_bytes,
                       {lipd_pkg::TAG_DELTA_HI, 4'($urandom_range(0, 15))}};
        repeat (chans / 2) image_bytes = {image_bytes, 8'($urandom_range(0, 255))};
      end else if (pick < 86) begin
        image_bytes = {image_bytes, lipd_pkg::TAG_FULL_PIXEL};
        add_raw_pixel();
      end else if (pick < 92) begin
        image_bytes = {image_bytes,
                       8'($urandom_range(lipd_tb_codes::TAG_BAD_LO,
                                         lipd_tb_codes::TAG_BAD_HI))};
      end else begin
        image_bytes = {image_bytes, 8'($urandom_range(0, 255))};
      end
    end
    foreach (image_bytes[i]) send_byte(image_bytes[i], i == image_bytes.size() - 1);
  endtask

  initial begin
    int unsigned mark;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, channel count at its reset value of 4 ----
    // first pixel raw, channel extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    // longest copy from farthest back: reaches before the first pixel
    send_byte({lipd_tb_codes::TAG_COPY_HI, 3'd7, 4'd15}, 1'b0);
    send_byte({lipd_tb_codes::TAG_COPY_HI, 3'd0, 4'd0}, 1'b0);
    // recall first and last index slots
    send_byte({lipd_tb_codes::TAG_INDEX_HI, 6'd0}, 1'b0);
    send_byte({lipd_tb_codes::TAG_INDEX_HI, 6'd63}, 1'b0);
    // delta at full magnitudes both ways, then a zero delta
    send_byte({lipd_pkg::TAG_DELTA_HI, 4'h7}, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte({lipd_pkg::TAG_DELTA_HI, 4'h8}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // full raw pixel
    send_byte(lipd_pkg::TAG_FULL_PIXEL, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    // unsupported tags
    send_byte(lipd_tb_codes::TAG_BAD_LO, 1'b0);
    send_byte(lipd_tb_codes::TAG_BAD_HI, 1'b0);
    send_byte(8'($urandom_range(lipd_tb_codes::TAG_BAD_LO, lipd_tb_codes::TAG_BAD_HI)), 1'b0);
    send_byte({lipd_tb_codes::TAG_COPY_HI, 3'd7, 4'd0}, 1'b0);
    // end of stream on a delta tag: the open token is dropped
    send_byte({lipd_pkg::TAG_DELTA_HI, 4'h3}, 1'b1);
    // half a first pixel, then shrink the channel count under it: the next
    // byte closes the pixel as gathered and is itself thrown away
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain(QUIET_CYC);
    set_channels(3'd2);
    send_byte(8'h56, 1'b0);
    send_byte({lipd_tb_codes::TAG_COPY_HI, 3'd0, 4'd1}, 1'b1);

    // ---- random images at two channels, then each planned setting ----
    mark = sent_bytes;
    while (sent_bytes - mark < PHASE_BYTES) send_image($urandom_range(2, 8));
    foreach (cfg_plan[p]) begin
      drain(QUIET_CYC);
      set_channels(cfg_plan[p]);
      mark = sent_bytes;
      while (sent_bytes - mark < PHASE_BYTES) send_image($urandom_range(2, 8));
    end

    drain(QUIET_CYC + 20);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### lossless_image_pixel_decoder.f
rtl/lipd_pkg.sv
rtl/lipd_front.sv
rtl/lipd_cmd_fifo.sv
rtl/lipd_back.sv
rtl/lossless_image_pixel_decoder.sv
rtl/lipd_checker.sv
sim/lipd_pixel_checker.sv
sim/lossless_image_pixel_decoder_tb.sv
